// ===== hdl/qst_pkg.sv =====
// Shared types, constants and helper functions for the query string tokenizer.
`default_nettype none
package qst_pkg;

	localparam int ByteW = 8;
	localparam int KindW = 2;

	// Kind codes carried with every result
	localparam logic [KindW-1:0] KIND_KEY      = 2'd0;
	localparam logic [KindW-1:0] KIND_VALUE    = 2'd1;
	localparam logic [KindW-1:0] KIND_PAIR_END = 2'd2;

	// Delimiter characters
	localparam logic [ByteW-1:0] CH_QUESTION = 8'h3F;
	localparam logic [ByteW-1:0] CH_EQUALS   = 8'h3D;
	localparam logic [ByteW-1:0] CH_AMP      = 8'h26;
	localparam logic [ByteW-1:0] CH_PERCENT  = 8'h25;
	localparam logic [ByteW-1:0] CH_PLUS     = 8'h2B;
	localparam logic [ByteW-1:0] CH_SPACE    = 8'h20;

	typedef struct packed {
		logic [ByteW-1:0] data;
		logic [KindW-1:0] kind;
		logic             bad;
		logic             last;
	} qst_result_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} qst_hex_t;

	// Decode one ASCII hex digit (0-9, a-f, A-F)
	function automatic qst_hex_t hex_decode(input logic [ByteW-1:0] c);
		qst_hex_t h;
		logic [ByteW-1:0] d;
		h = '0;
		d = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
			h.valid = 1'b1;
			h.value = d[3:0];
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
			h.valid = 1'b1;
			h.value = d[3:0];
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
			h.valid = 1'b1;
			h.value = d[3:0];
		end
		return h;
	endfunction

	function automatic qst_result_t make_result(input logic [ByteW-1:0] data,
		input logic [KindW-1:0] kind, input logic bad);
		qst_result_t r;
		r.data = data;
		r.kind = kind;
		r.bad  = bad;
		r.last = 1'b0;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/query_string_tokenizer.sv =====
// Top level of the query string tokenizer: parse state and two-entry result buffer.
// The first result of a request is offered on the master side in the cycle after the request is accepted.
// Throughput: one URI byte per cycle while m_tready is high; a byte that yields two results holds
//   the slave side until its first result has been taken, set by the single-result output port.
// Reset: arst_n clears the parse state and empties the result buffer asynchronously.
// A request with tlast set returns the parser to its reset state after its results.
`default_nettype none
module query_string_tokenizer import qst_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// slave side: URI bytes
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [ByteW-1:0] s_tdata,   // [7:0] in_byte
	input  wire logic             s_tlast,   // in_last
	// master side: tokens
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [ByteW-1:0]      m_tdata,   // [7:0] out_byte
	output logic [KindW:0]        m_tuser,   // [1:0] out_kind, [2] bad_escape
	output logic                  m_tlast    // out_last
);

	typedef enum logic [1:0] {
		PH_SKIP  = 2'd0,  // before the first '?'
		PH_KEY   = 2'd1,
		PH_VALUE = 2'd2
	} phase_t;

	// parse state
	phase_t     phase_q;
	logic [1:0] esc_q;       // 0 no escape, 1 after '%', 2 after first escape byte
	logic [3:0] nibble_q;    // value of first escape digit
	logic       nib_ok_q;    // first escape byte was a hex digit
	logic       pair_open_q;

	// next state
	phase_t     phase_d;
	logic [1:0] esc_d;
	logic [3:0] nibble_d;
	logic       nib_ok_d;
	logic       pair_open_d;

	// results of the current request
	qst_result_t res_d [2];
	logic [1:0]  n_d;

	// output buffer: slot 0 is presented, slot 1 waits behind it
	qst_result_t slot0_q, slot1_q;
	logic [1:0]  cnt_q;

	logic     s_fire, m_fire;
	qst_hex_t hx;
	logic     in_pair;

	assign s_fire = s_tvalid & s_tready;
	assign m_fire = m_tvalid & m_tready;

	// Take a new request when the buffer is empty or its only result leaves this cycle.
	assign s_tready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_tready);

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = slot0_q.data;
	assign m_tuser  = {slot0_q.bad, slot0_q.kind};
	assign m_tlast  = slot0_q.last;

	assign hx      = hex_decode(s_tdata);
	assign in_pair = (phase_q == PH_KEY) || (phase_q == PH_VALUE);

	// Parse one byte: next state and up to two results.
	always_comb begin
		phase_d     = phase_q;
		esc_d       = esc_q;
		nibble_d    = nibble_q;
		nib_ok_d    = nib_ok_q;
		pair_open_d = pair_open_q;
		res_d[0]    = '0;
		res_d[1]    = '0;
		n_d         = 2'd0;

		if (in_pair) begin
			pair_open_d = 1'b1;
			if (s_tdata == CH_AMP) begin
				// close the pair, flushing a cut-short escape first
				if (esc_q != 2'd0) begin
					res_d[n_d[0]] = make_result(((esc_q == 2'd2) && nib_ok_q) ?
						{4'd0, nibble_q} : '0, KIND_VALUE, 1'b1);
					n_d   = n_d + 2'd1;
					esc_d = 2'd0;
				end
				res_d[n_d[0]] = make_result('0, KIND_PAIR_END, 1'b0);
				n_d         = n_d + 2'd1;
				pair_open_d = 1'b0;
				phase_d     = PH_KEY;
			end else if (phase_q == PH_KEY) begin
				if (s_tdata == CH_EQUALS) begin
					phase_d = PH_VALUE;
				end else begin
					res_d[n_d[0]] = make_result(s_tdata, KIND_KEY, 1'b0);
					n_d = n_d + 2'd1;
				end
			end else if (esc_q == 2'd1) begin
				// hold the first escape digit
				nib_ok_d = hx.valid;
				nibble_d = hx.valid ? hx.value : 4'd0;
				esc_d    = 2'd2;
			end else if (esc_q == 2'd2) begin
				if (nib_ok_q && hx.valid) begin
					res_d[n_d[0]] = make_result({nibble_q, hx.value}, KIND_VALUE, 1'b0);
				end else if (nib_ok_q) begin
					res_d[n_d[0]] = make_result({4'd0, nibble_q}, KIND_VALUE, 1'b1);
				end else begin
					res_d[n_d[0]] = make_result('0, KIND_VALUE, 1'b1);
				end
				n_d   = n_d + 2'd1;
				esc_d = 2'd0;
			end else if (s_tdata == CH_PERCENT) begin
				esc_d = 2'd1;
			end else if (s_tdata == CH_PLUS) begin
				res_d[n_d[0]] = make_result(CH_SPACE, KIND_VALUE, 1'b0);
				n_d = n_d + 2'd1;
			end else begin
				res_d[n_d[0]] = make_result(s_tdata, KIND_VALUE, 1'b0);
				n_d = n_d + 2'd1;
			end
		end else if (s_tdata == CH_QUESTION) begin
			phase_d     = PH_KEY;
			pair_open_d = 1'b0;
			esc_d       = 2'd0;
		end

		if (s_tlast) begin
			// end of URI: close an open pair, then drop back to reset state
			if ((phase_d != PH_SKIP) && pair_open_d) begin
				if (esc_d != 2'd0) begin
					res_d[n_d[0]] = make_result(((esc_d == 2'd2) && nib_ok_d) ?
						{4'd0, nibble_d} : '0, KIND_VALUE, 1'b1);
					n_d = n_d + 2'd1;
				end
				res_d[n_d[0]] = make_result('0, KIND_PAIR_END, 1'b0);
				n_d = n_d + 2'd1;
			end
			phase_d     = PH_SKIP;
			esc_d       = 2'd0;
			nibble_d    = 4'd0;
			nib_ok_d    = 1'b0;
			pair_open_d = 1'b0;
		end

		// mark the final result of this request
		if (n_d == 2'd1) begin
			res_d[0].last = 1'b1;
		end else if (n_d == 2'd2) begin
			res_d[1].last = 1'b1;
		end
	end

	// parse state advances on every accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SKIP;
			esc_q       <= 2'd0;
			nibble_q    <= 4'd0;
			nib_ok_q    <= 1'b0;
			pair_open_q <= 1'b0;
		end else if (s_fire) begin
			phase_q     <= phase_d;
			esc_q       <= esc_d;
			nibble_q    <= nibble_d;
			nib_ok_q    <= nib_ok_d;
			pair_open_q <= pair_open_d;
		end
	end

	// result buffer occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (s_fire) begin
			cnt_q <= n_d;
		end else if (m_fire) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// result payload: load both slots on a request, else advance slot 1 on a take
	always_ff @(posedge clk) begin
		if (s_fire) begin
			slot0_q <= res_d[0];
			slot1_q <= res_d[1];
		end else if (m_fire) begin
			slot0_q <= slot1_q;
		end
	end

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the query string tokenizer: stream stimulus, prediction, checks.
`timescale 1ns / 1ps
module tb_top;
	import qst_pkg::*;

	localparam int CYCLE_LIMIT    = 200000;
	localparam int PHASE_REQUESTS = 315;
	localparam int TAIL_CYCLES    = 16;

	// Parse position and escape progress of the predictor
	typedef enum logic [1:0] {SCAN_PATH, SCAN_KEY, SCAN_VALUE} scan_t;
	typedef enum logic [1:0] {ESC_NONE, ESC_OPENED, ESC_ONE_DIGIT} esc_t;

	// Predicts the tokens of every accepted URI byte and checks the token stream against them.
	class token_scoreboard;
		scan_t       scan;
		esc_t        esc;
		logic [3:0]  hi_nibble;
		logic        hi_valid;
		logic        pair_open;
		qst_result_t tokens_due[$];
		int          mismatches = 0;

		function void clear_state();
			scan      = SCAN_PATH;
			esc       = ESC_NONE;
			hi_nibble = 4'h0;
			hi_valid  = 1'b0;
			pair_open = 1'b0;
		endfunction

		function int nibble_of(logic [7:0] c);
			if (c >= "0" && c <= "9") return int'(c) - int'("0");
			if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
			if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
			return -1;
		endfunction

		function void push_token(logic [7:0] d, logic [KindW-1:0] k, logic bad);
			qst_result_t r;
			r.data = d;
			r.kind = k;
			r.bad  = bad;
			r.last = 1'b0;
			tokens_due.push_back(r);
		endfunction

		// Emit what an unfinished escape leaves behind, flagged as bad
		function void close_escape();
			if (esc == ESC_ONE_DIGIT && hi_valid)
				push_token({4'h0, hi_nibble}, KIND_VALUE, 1'b1);
			else
				push_token(8'h00, KIND_VALUE, 1'b1);
			esc = ESC_NONE;
		endfunction

		function int pending();
			return tokens_due.size();
		endfunction

		function void note_request(logic [7:0] b, logic fin);
			int          h;
			int          base;
			qst_result_t r;
			base = tokens_due.size();
			if (scan == SCAN_KEY || scan == SCAN_VALUE) begin
				pair_open = 1'b1;
				if (b == CH_AMP) begin
					if (esc != ESC_NONE)
						close_escape();
					push_token(8'h00, KIND_PAIR_END, 1'b0);
					pair_open = 1'b0;
					scan      = SCAN_KEY;
				end else if (scan == SCAN_KEY) begin
					if (b == CH_EQUALS)
						scan = SCAN_VALUE;
					else
						push_token(b, KIND_KEY, 1'b0);
				end else if (esc == ESC_OPENED) begin
					h         = nibble_of(b);
					hi_valid  = (h >= 0);
					hi_nibble = hi_valid ? h[3:0] : 4'h0;
					esc       = ESC_ONE_DIGIT;
				end else if (esc == ESC_ONE_DIGIT) begin
					h = nibble_of(b);
					if (hi_valid && h >= 0)
						push_token({hi_nibble, h[3:0]}, KIND_VALUE, 1'b0);
					else if (hi_valid)
						push_token({4'h0, hi_nibble}, KIND_VALUE, 1'b1);
					else
						push_token(8'h00, KIND_VALUE, 1'b1);
					esc = ESC_NONE;
				end else if (b == CH_PERCENT) begin
					esc = ESC_OPENED;
				end else if (b == CH_PLUS) begin
					push_token(CH_SPACE, KIND_VALUE, 1'b0);
				end else begin
					push_token(b, KIND_VALUE, 1'b0);
				end
			end else if (b == CH_QUESTION) begin
				scan      = SCAN_KEY;
				pair_open = 1'b0;
				esc       = ESC_NONE;
			end
			if (fin) begin
				if (scan != SCAN_PATH && pair_open) begin
					if (esc != ESC_NONE)
						close_escape();
					push_token(8'h00, KIND_PAIR_END, 1'b0);
				end
				clear_state();
			end
			// Flag the final token of this request
			if (tokens_due.size() > base) begin
				r      = tokens_due.pop_back();
				r.last = 1'b1;
				tokens_due.push_back(r);
			end
		endfunction

		function void check_token(logic [7:0] d, logic [KindW:0] user, logic l);
			qst_result_t want;
			if (tokens_due.size() == 0) begin
				$error("token with no request pending: out_byte %0h out_kind %0d", d,
					user[KindW-1:0]);
				mismatches++;
				return;
			end
			want = tokens_due.pop_front();
			if (d !== want.data) begin
				$error("out_byte mismatch: expected %0h, actual %0h", want.data, d);
				mismatches++;
			end
			if (user[KindW-1:0] !== want.kind) begin
				$error("out_kind mismatch: expected %0d, actual %0d", want.kind,
					user[KindW-1:0]);
				mismatches++;
			end
			if (user[KindW] !== want.bad) begin
				$error("bad_escape mismatch: expected %0b, actual %0b", want.bad, user[KindW]);
				mismatches++;
			end
			if (l !== want.last) begin
				$error("out_last mismatch: expected %0b, actual %0b", want.last, l);
				mismatches++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [ByteW-1:0] s_tdata;   // [7:0] in_byte
	logic             s_tlast;   // in_last
	logic             m_tvalid;
	logic             m_tready;
	logic [ByteW-1:0] m_tdata;   // [7:0] out_byte
	logic [KindW:0]   m_tuser;   // [1:0] out_kind, [2] bad_escape
	logic             m_tlast;   // out_last

	token_scoreboard sb;
	logic [7:0]      uri_bytes[$];
	int              send_idle_pct;
	int              recv_stall_pct;
	int              requests_sent;
	int              cycles;

	query_string_tokenizer DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Roll the receiver's stall fresh every cycle; a zero rate gives a steady ready
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Check every token that the master side hands over
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_token(m_tdata, m_tuser, m_tlast);
	end

	// Watchdog: end a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Any byte that cannot start a hex digit
	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (sb.nibble_of(c) >= 0);
		return c;
	endfunction

	// Hex digit in random letter case
	function automatic logic [7:0] hex_char();
		int v;
		v = $urandom_range(15);
		if (v < 10)
			return 8'(int'("0") + v);
		return 8'(($urandom_range(1) ? int'("A") : int'("a")) + v - 10);
	endfunction

	// Ordinary byte: no delimiter and no escape start
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do c = 8'($urandom_range(255));
		while (c == CH_AMP || c == CH_PERCENT || c == CH_EQUALS || c == CH_QUESTION);
		return c;
	endfunction

	// Build one random URI: mostly well-formed queries with random content, some noise
	function automatic void make_uri();
		int pairs;
		uri_bytes.delete();
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(12, 1)) uri_bytes.push_back(8'($urandom_range(255)));
			return;
		end
		repeat ($urandom_range(3)) uri_bytes.push_back(plain_char());
		// Occasionally leave the query out entirely
		if ($urandom_range(19) == 0) begin
			uri_bytes.push_back(plain_char());
			return;
		end
		uri_bytes.push_back(CH_QUESTION);
		pairs = $urandom_range(4, 1);
		for (int p = 0; p < pairs; p++) begin
			if (p > 0)
				uri_bytes.push_back(CH_AMP);
			repeat ($urandom_range(4)) uri_bytes.push_back(plain_char());
			if ($urandom_range(6) != 0) begin
				uri_bytes.push_back(CH_EQUALS);
				repeat ($urandom_range(5)) begin
					case ($urandom_range(9))
						0: uri_bytes.push_back(CH_PLUS);
						1, 2: begin
							uri_bytes.push_back(CH_PERCENT);
							uri_bytes.push_back(hex_char());
							uri_bytes.push_back(hex_char());
						end
						3: begin
							uri_bytes.push_back(CH_PERCENT);
							uri_bytes.push_back(hex_char());
							uri_bytes.push_back(non_hex_char());
						end
						4: begin
							uri_bytes.push_back(CH_PERCENT);
							uri_bytes.push_back(non_hex_char());
							uri_bytes.push_back(8'($urandom_range(255)));
						end
						5: uri_bytes.push_back($urandom_range(1) ? CH_EQUALS : CH_QUESTION);
						default: uri_bytes.push_back(plain_char());
					endcase
				end
			end
		end
		// Cut an escape short at the URI end, or close with a trailing separator
		case ($urandom_range(7))
			0: uri_bytes.push_back(CH_PERCENT);
			1: begin
				uri_bytes.push_back(CH_PERCENT);
				uri_bytes.push_back(hex_char());
			end
			2: uri_bytes.push_back(CH_AMP);
			default: ;
		endcase
	endfunction

	// Offer one request at the falling edge, idling first at the sender's rate;
	// hold it until the slave side takes it
	task automatic offer_request(input logic [7:0] b, input logic fin);
		logic taken;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = s_tready;
		end
		sb.note_request(b, fin);
		requests_sent++;
	endtask

	task automatic send_uri();
		foreach (uri_bytes[i])
			offer_request(uri_bytes[i], i == uri_bytes.size() - 1);
	endtask

	// Drop valid and wait until every predicted token has come out
	task automatic drain_tokens();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int idle_plan[4];
		int stall_plan[4];
		int phase_start;
		idle_plan  = '{0, 87, 0, 10};
		stall_plan = '{0, 0, 87, 10};
		sb = new;
		sb.clear_state();
		cycles         = 0;
		requests_sent  = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tlast        = 1'b0;
		m_tready       = 1'b0;
		arst_n         = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: delimiters, ordinary '?' and '=' inside a value, '+', a good escape,
		// bad second and bad first escape bytes, an empty pair, a key with no '=',
		// an empty key, and an escape cut short by the URI end
		uri_bytes = '{CH_QUESTION, 8'h00, CH_EQUALS, CH_EQUALS, CH_QUESTION, CH_PLUS,
			CH_PERCENT, "4", "F", CH_PERCENT, "a", "z", CH_PERCENT, "g", "1",
			CH_AMP, CH_AMP, "x", CH_AMP, CH_EQUALS, CH_PERCENT, "7"};
		send_uri();
		// Escape cut short by '&', which is also the final byte
		uri_bytes = '{CH_QUESTION, CH_EQUALS, CH_PERCENT, CH_AMP};
		send_uri();
		// No query at all, then a lone final '?'
		uri_bytes = '{8'hFF};
		send_uri();
		uri_bytes = '{CH_QUESTION};
		send_uri();

		// Random phases, each ending with the sender held until all tokens are out
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = idle_plan[ph];
			recv_stall_pct = stall_plan[ph];
			phase_start    = requests_sent;
			while (requests_sent - phase_start < PHASE_REQUESTS) begin
				make_uri();
				send_uri();
			end
			drain_tokens();
		end

		// Let any stray token show up before judging
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== query_string_tokenizer.f =====
hdl/qst_pkg.sv
hdl/query_string_tokenizer.sv
verif/tb_top.sv
